// File: rtl/core/svp_pkg.sv
// ----------------------------------------------------------------------------
// svp_pkg
// Shared types and constants of the streaming vertex partitioner.
// ----------------------------------------------------------------------------
`default_nettype none
package svp_pkg;
    localparam int VID_W      = 16;
    localparam int MAP_DEPTH  = 65536;
    localparam int MAX_PARTS  = 16;
    localparam int PART_W     = 4;
    localparam int MAP_W      = 5;
    localparam int CNT_W      = 17;
    localparam int NP_W       = 5;
    localparam int ALPHA_W    = 20;
    localparam int COST_W     = 26;
    localparam int SQ_IN_W    = 18;
    localparam int ROOT_W     = 25;
    localparam int F_W        = SQ_IN_W + ROOT_W;
    localparam int PROD_W     = ALPHA_W + COST_W;
    localparam int PEN_W      = PROD_W - 16;
    localparam int SCORE_W    = CNT_W + 18;
    localparam int CLR_W      = VID_W + 1;

    localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
    localparam logic [COST_W-1:0] COST_RESET = COST_W'(65536);
    localparam logic [MAP_W-1:0]  UNASSIGNED = MAP_W'(MAX_PARTS);
    localparam logic [NP_W-1:0]   PARTS_MAX  = NP_W'(MAX_PARTS);

    localparam logic CFG_NUM_PARTS = 1'b0;
    localparam logic CFG_ALPHA     = 1'b1;

    typedef struct packed {
        logic [VID_W-1:0] vertex_id;
        logic [VID_W-1:0] neighbor_id;
        logic             has_neighbor;
        logic             last;
    } t_in_item;

    typedef struct packed {
        logic [VID_W-1:0]  placed_vertex;
        logic [PART_W-1:0] chosen_part;
        logic [VID_W-1:0]  shared_neighbors;
        logic              seeded;
    } t_out_item;

    typedef struct packed {
        logic [NP_W-1:0]    part_count;
        logic [ALPHA_W-1:0] alpha_weight;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_LOOK, ST_HIT, ST_DECIDE, ST_MUL, ST_CMP,
        ST_PLACE, ST_SQ1, ST_W1, ST_SQ0, ST_W0, ST_COST, ST_EMIT
    } t_state;
endpackage
`default_nettype wire

// File: rtl/core/svp_fifo.sv
// ----------------------------------------------------------------------------
// svp_fifo
// Two-entry queue between the input port and the placement engine.
// ----------------------------------------------------------------------------
`default_nettype none
module svp_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire svp_pkg::t_in_item i_item,
    output logic                   o_valid,
    input  wire logic              i_pop,
    output svp_pkg::t_in_item      o_item
);
    svp_pkg::t_in_item r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_item;
    end
endmodule
`default_nettype wire

// File: rtl/core/svp_isqrt.sv
// ----------------------------------------------------------------------------
// svp_isqrt
// Bit-pair restoring square root of (x << 32), one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module svp_isqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [svp_pkg::SQ_IN_W-1:0]  i_x,
    output logic                              o_done,
    output logic [svp_pkg::ROOT_W-1:0]        o_root
);
    localparam int XW = 2 * svp_pkg::ROOT_W;
    localparam int RW = svp_pkg::ROOT_W + 3;

    logic          r_busy, r_done;
    logic [4:0]    r_cnt;
    logic [XW-1:0] r_x;
    logic [RW-1:0] r_rem;
    logic [svp_pkg::ROOT_W-1:0] r_root;
    logic [RW-1:0] w_rem2, w_trial;

    assign w_rem2  = {r_rem[RW-3:0], r_x[XW-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign o_done  = r_done;
    assign o_root  = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(svp_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= {i_x, 32'b0};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x <= {r_x[XW-3:0], 2'b00};
            if (w_rem2 >= w_trial) begin
                r_rem  <= w_rem2 - w_trial;
                r_root <= {r_root[svp_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem2;
                r_root <= {r_root[svp_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/svp_back.sv
// ----------------------------------------------------------------------------
// svp_back
// Placement engine: neighbour lookups, partition scan, cost update, result.
// ----------------------------------------------------------------------------
`default_nettype none
module svp_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire svp_pkg::t_cfg      i_cfg,
    input  wire logic               i_in_valid,
    input  wire svp_pkg::t_in_item  i_item,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output svp_pkg::t_out_item      o_result
);
    logic [svp_pkg::MAP_W-1:0]          r_map [svp_pkg::MAP_DEPTH];
    logic [svp_pkg::MAP_W-1:0]          r_map_q;
    logic [svp_pkg::CLR_W-1:0]          r_clr_addr;

    svp_pkg::t_state                    r_state, n_state;
    svp_pkg::t_in_item                  r_item;
    logic [svp_pkg::CNT_W-1:0]          r_size [svp_pkg::MAX_PARTS];
    logic [svp_pkg::COST_W-1:0]         r_cost [svp_pkg::MAX_PARTS];
    logic [svp_pkg::CNT_W-1:0]          r_hits [svp_pkg::MAX_PARTS];
    logic [svp_pkg::CNT_W-1:0]          r_placed;
    logic [svp_pkg::NP_W-1:0]           r_k;
    logic [svp_pkg::PART_W-1:0]         r_p, r_chosen;
    logic                               r_seed;
    logic [svp_pkg::CNT_W-1:0]          r_shared;
    logic [svp_pkg::PEN_W-1:0]          r_pen;
    logic signed [svp_pkg::SCORE_W-1:0] r_best;
    logic [svp_pkg::SQ_IN_W-1:0]        r_sq_x;
    logic [svp_pkg::F_W-1:0]            r_f1, r_f0;

    logic [svp_pkg::NP_W-1:0]           w_k;
    logic [svp_pkg::PROD_W-1:0]         w_prod;
    logic signed [svp_pkg::SCORE_W-1:0] w_score;
    logic [svp_pkg::F_W-1:0]            w_f, w_fdiff;
    logic                               w_sq_start, w_sq_done;
    logic [svp_pkg::ROOT_W-1:0]         w_root;
    logic                               w_map_we;
    logic [svp_pkg::VID_W-1:0]          w_map_addr;
    logic [svp_pkg::MAP_W-1:0]          w_map_data;

    // 0 acts as one partition, anything above the maximum as the maximum
    always_comb begin
        if (i_cfg.part_count == '0) begin
            w_k = svp_pkg::NP_W'(1);
        end else if (i_cfg.part_count > svp_pkg::PARTS_MAX) begin
            w_k = svp_pkg::PARTS_MAX;
        end else begin
            w_k = i_cfg.part_count;
        end
    end

    assign w_prod  = svp_pkg::PROD_W'(i_cfg.alpha_weight) * svp_pkg::PROD_W'(r_cost[r_p]);
    assign w_score = $signed(svp_pkg::SCORE_W'({r_hits[r_p], 16'h0000}))
                   - $signed(svp_pkg::SCORE_W'(r_pen));
    assign w_f     = svp_pkg::F_W'(r_sq_x) * svp_pkg::F_W'(w_root);
    assign w_fdiff = r_f1 - r_f0;

    assign o_result = '{
        placed_vertex:    r_item.vertex_id,
        chosen_part:      r_chosen,
        shared_neighbors: r_shared[svp_pkg::CNT_W-1] ? '1 : r_shared[svp_pkg::VID_W-1:0],
        seeded:           r_seed
    };

    svp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_x     (r_sq_x),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= svp_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        o_valid    = 1'b0;
        w_sq_start = 1'b0;
        w_map_we   = 1'b0;
        w_map_addr = r_item.vertex_id;
        w_map_data = {1'b0, r_chosen};
        case (r_state)
            svp_pkg::ST_CLEAR: begin
                w_map_we   = 1'b1;
                w_map_addr = r_clr_addr[svp_pkg::VID_W-1:0];
                w_map_data = svp_pkg::UNASSIGNED;
                if (r_clr_addr == svp_pkg::CLR_W'(svp_pkg::MAP_DEPTH - 1)) begin
                    n_state = svp_pkg::ST_IDLE;
                end
            end
            svp_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_pop = 1'b1;
                    if (i_item.has_neighbor) begin
                        n_state = svp_pkg::ST_LOOK;
                    end else if (i_item.last) begin
                        n_state = svp_pkg::ST_DECIDE;
                    end
                end
            end
            svp_pkg::ST_LOOK: begin
                n_state = svp_pkg::ST_HIT;
            end
            svp_pkg::ST_HIT: begin
                n_state = r_item.last ? svp_pkg::ST_DECIDE : svp_pkg::ST_IDLE;
            end
            svp_pkg::ST_DECIDE: begin
                n_state = (r_placed < svp_pkg::CNT_W'(w_k)) ? svp_pkg::ST_PLACE
                                                            : svp_pkg::ST_MUL;
            end
            svp_pkg::ST_MUL: begin
                n_state = svp_pkg::ST_CMP;
            end
            svp_pkg::ST_CMP: begin
                n_state = (svp_pkg::NP_W'(r_p) == r_k - svp_pkg::NP_W'(1))
                        ? svp_pkg::ST_PLACE : svp_pkg::ST_MUL;
            end
            svp_pkg::ST_PLACE: begin
                w_map_we = 1'b1;
                n_state  = (r_size[r_chosen] != svp_pkg::CNT_MAX) ? svp_pkg::ST_SQ1
                                                                  : svp_pkg::ST_EMIT;
            end
            svp_pkg::ST_SQ1: begin
                w_sq_start = 1'b1;
                n_state    = svp_pkg::ST_W1;
            end
            svp_pkg::ST_W1: begin
                if (w_sq_done) n_state = svp_pkg::ST_SQ0;
            end
            svp_pkg::ST_SQ0: begin
                w_sq_start = 1'b1;
                n_state    = svp_pkg::ST_W0;
            end
            svp_pkg::ST_W0: begin
                if (w_sq_done) n_state = svp_pkg::ST_COST;
            end
            svp_pkg::ST_COST: begin
                n_state = svp_pkg::ST_EMIT;
            end
            svp_pkg::ST_EMIT: begin
                o_valid = 1'b1;
                if (i_ready) n_state = svp_pkg::ST_IDLE;
            end
            default: begin
                n_state = svp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_map_we) r_map[w_map_addr] <= w_map_data;
        r_map_q <= r_map[r_item.neighbor_id];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_placed   <= '0;
            for (int p = 0; p < svp_pkg::MAX_PARTS; p++) begin
                r_size[p] <= '0;
                r_cost[p] <= svp_pkg::COST_RESET;
                r_hits[p] <= '0;
            end
        end else begin
            case (r_state)
                svp_pkg::ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + svp_pkg::CLR_W'(1);
                end
                svp_pkg::ST_IDLE: begin
                    if (i_in_valid) r_item <= i_item;
                end
                svp_pkg::ST_HIT: begin
                    // unassigned entries have the top bit set
                    if (!r_map_q[svp_pkg::MAP_W-1]
                        && r_hits[r_map_q[svp_pkg::PART_W-1:0]] != svp_pkg::CNT_MAX) begin
                        r_hits[r_map_q[svp_pkg::PART_W-1:0]] <=
                            r_hits[r_map_q[svp_pkg::PART_W-1:0]] + svp_pkg::CNT_W'(1);
                    end
                end
                svp_pkg::ST_DECIDE: begin
                    r_k    <= w_k;
                    r_p    <= '0;
                    r_seed <= (r_placed < svp_pkg::CNT_W'(w_k));
                    if (r_placed < svp_pkg::CNT_W'(w_k)) begin
                        r_chosen <= r_placed[svp_pkg::PART_W-1:0];
                    end
                end
                svp_pkg::ST_MUL: begin
                    r_pen <= w_prod[svp_pkg::PROD_W-1:16];
                end
                svp_pkg::ST_CMP: begin
                    if (r_p == '0 || w_score > r_best) begin
                        r_best   <= w_score;
                        r_chosen <= r_p;
                    end
                    r_p <= r_p + svp_pkg::PART_W'(1);
                end
                svp_pkg::ST_PLACE: begin
                    r_shared <= r_seed ? '0 : r_hits[r_chosen];
                    for (int p = 0; p < svp_pkg::MAX_PARTS; p++) r_hits[p] <= '0;
                    if (r_placed != svp_pkg::CNT_MAX) r_placed <= r_placed + svp_pkg::CNT_W'(1);
                    if (r_size[r_chosen] != svp_pkg::CNT_MAX) begin
                        r_size[r_chosen] <= r_size[r_chosen] + svp_pkg::CNT_W'(1);
                        // new size plus one, for F(s+1)
                        r_sq_x <= svp_pkg::SQ_IN_W'(r_size[r_chosen]) + svp_pkg::SQ_IN_W'(2);
                    end
                end
                svp_pkg::ST_W1: begin
                    if (w_sq_done) begin
                        r_f1   <= w_f;
                        r_sq_x <= r_sq_x - svp_pkg::SQ_IN_W'(1);
                    end
                end
                svp_pkg::ST_W0: begin
                    if (w_sq_done) r_f0 <= w_f;
                end
                svp_pkg::ST_COST: begin
                    r_cost[r_chosen] <= w_fdiff[svp_pkg::COST_W-1:0];
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/streaming_vertex_partitioner.sv
// ----------------------------------------------------------------------------
// streaming_vertex_partitioner
// Greedy streaming graph partitioner with a balance-weighted cost term.
// ----------------------------------------------------------------------------
// After reset the vertex map is swept to "unassigned", one entry a cycle, over
// all 65536 entries; up to two transactions queue meanwhile. A neighbour item
// then needs a map read; an item without a neighbour needs none. A closing
// item that does not seed a partition runs the score scan (one multiply and
// one compare per partition in use), and two 25-step square roots then
// rebuild the chosen partition's cost term.
`default_nettype none
module streaming_vertex_partitioner (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire svp_pkg::t_in_item             i_item,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output svp_pkg::t_out_item                 o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [svp_pkg::ALPHA_W-1:0]   i_cfg_wdata
);
    svp_pkg::t_cfg     r_cfg;
    svp_pkg::t_in_item w_head;
    logic              w_head_valid, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.part_count   <= svp_pkg::NP_W'(2);
            r_cfg.alpha_weight <= svp_pkg::ALPHA_W'(32768);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                svp_pkg::CFG_NUM_PARTS: r_cfg.part_count <= i_cfg_wdata[svp_pkg::NP_W-1:0];
                svp_pkg::CFG_ALPHA:     r_cfg.alpha_weight <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    svp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (w_head_valid),
        .i_pop   (w_pop),
        .o_item  (w_head)
    );

    svp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (w_head_valid),
        .i_item     (w_head),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (o_result)
    );
endmodule
`default_nettype wire

// File: rtl/core/svp_checker.sv
// ----------------------------------------------------------------------------
// svp_checker
// Port-level checks on the streaming vertex partitioner.
// ----------------------------------------------------------------------------
`default_nettype none
module svp_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire svp_pkg::t_out_item o_result
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("result dropped or changed while stalled");

    a_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.seeded |-> o_result.shared_neighbors == '0)
        else $error("seed placement reports shared neighbours");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");
endmodule

bind streaming_vertex_partitioner svp_checker u_svp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_result (o_result)
);
`default_nettype wire

// File: tb/tb_streaming_vertex_partitioner.sv
// ----------------------------------------------------------------------------
// tb_streaming_vertex_partitioner
// Self-checking bench: streams vertices through the partitioner under
// bursty input and a stalling output. A built-in placement predictor keeps
// its own map, sizes and cost terms. Results are checked in order against it.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_streaming_vertex_partitioner;

    localparam int  DRAIN_CYCLES = 400;
    localparam int  CYCLE_LIMIT  = 2000000;
    localparam int  LONG_STALL   = 3000;
    localparam int  PHASE_ITEMS  = 215;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    svp_pkg::t_in_item           i_item = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    svp_pkg::t_out_item          o_result;
    logic                        i_cfg_we = 1'b0;
    logic                        i_cfg_index = svp_pkg::CFG_NUM_PARTS;
    logic [svp_pkg::ALPHA_W-1:0] i_cfg_wdata = '0;

    streaming_vertex_partitioner u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------- placement predictor state ----------------
    logic [4:0]  pm_map [svp_pkg::MAP_DEPTH];
    logic [16:0] pm_size [svp_pkg::MAX_PARTS];
    logic [63:0] pm_cost [svp_pkg::MAX_PARTS];
    logic [16:0] pm_hits [svp_pkg::MAX_PARTS];
    logic [16:0] pm_placed;
    logic [4:0]  pm_part_count;
    logic [19:0] pm_alpha;

    svp_pkg::t_in_item  pending_items [$];
    svp_pkg::t_out_item expected_placements [$];
    logic [15:0] known_ids [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          cycles = 0;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] pow_three_halves(input logic [63:0] x);
        return x * floor_sqrt(x << 32);
    endfunction

    task automatic place_vertex(input svp_pkg::t_in_item it);
        int          k;
        int          chosen;
        logic        seed;
        logic [16:0] shared;
        logic signed [63:0] best;
        logic signed [63:0] score;
        logic [63:0] pen;
        logic [4:0]  q;
        logic [63:0] s;
        svp_pkg::t_out_item r;
        if (it.has_neighbor) begin
            q = pm_map[it.neighbor_id];
            if (q < svp_pkg::MAX_PARTS && pm_hits[q] != svp_pkg::CNT_MAX)
                pm_hits[q] = pm_hits[q] + 17'd1;
        end
        if (!it.last) return;
        k = int'(pm_part_count);
        if (k == 0) k = 1;
        if (k > svp_pkg::MAX_PARTS) k = svp_pkg::MAX_PARTS;
        best = '0;
        chosen = 0;
        if (int'(pm_placed) < k) begin
            seed = 1'b1;
            chosen = int'(pm_placed);
            shared = '0;
        end else begin
            seed = 1'b0;
            for (int p = 0; p < k; p++) begin
                pen = (64'(pm_alpha) * pm_cost[p]) >> 16;
                score = $signed(64'(pm_hits[p]) << 16) - $signed(pen);
                if (p == 0 || score > best) begin
                    best = score;
                    chosen = p;
                end
            end
            shared = pm_hits[chosen];
        end
        pm_map[it.vertex_id] = 5'(chosen);
        if (pm_size[chosen] != svp_pkg::CNT_MAX) begin
            s = 64'(pm_size[chosen]) + 64'd1;
            pm_size[chosen] = 17'(s);
            pm_cost[chosen] = pow_three_halves(s + 64'd1) - pow_three_halves(s);
        end
        if (pm_placed != svp_pkg::CNT_MAX) pm_placed = pm_placed + 17'd1;
        for (int p = 0; p < svp_pkg::MAX_PARTS; p++) pm_hits[p] = '0;
        r.placed_vertex    = it.vertex_id;
        r.chosen_part      = svp_pkg::PART_W'(chosen);
        r.shared_neighbors = (shared > 17'hFFFF) ? 16'hFFFF : shared[15:0];
        r.seeded           = seed;
        expected_placements.push_back(r);
    endtask

    // ---------------- driver ----------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) place_vertex(i_item);
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    i_item  <= pending_items.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left = burst_left - 1;
                    end else begin
                        burst_left = int'($urandom_range(0, 40));
                        gap_left = ($urandom_range(0, 3) == 0) ? 0
                                 : int'($urandom_range(1, 8));
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    int  stall_left = 0;
    bit  long_stall_done = 0;
    int  ready_mode = 0;

    always @(posedge i_clk) begin
        svp_pkg::t_out_item exp_r;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen = results_seen + 1;
                if (expected_placements.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: %p", o_result);
                end else begin
                    exp_r = expected_placements.pop_front();
                    if (o_result.placed_vertex !== exp_r.placed_vertex
                        || o_result.chosen_part !== exp_r.chosen_part
                        || o_result.shared_neighbors !== exp_r.shared_neighbors
                        || o_result.seeded !== exp_r.seeded) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: exp %p got %p", exp_r, o_result);
                    end
                end
            end
            if (!long_stall_done && results_seen == 300) begin
                long_stall_done = 1;
                stall_left = LONG_STALL;
            end
            if (cycles % 64 == 0) ready_mode = int'($urandom_range(0, 2));
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_ready <= 1'b0;
            end else begin
                case (ready_mode)
                    0: begin
                        i_ready <= 1'b1;
                    end
                    1: begin
                        i_ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        i_ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic push_item(input logic [15:0] vid, input logic [15:0] nid,
                             input logic has_nb, input logic lst);
        svp_pkg::t_in_item it;
        it.vertex_id = vid;
        it.neighbor_id = nid;
        it.has_neighbor = has_nb;
        it.last = lst;
        pending_items.push_back(it);
        if (lst) begin
            known_ids.push_back(vid);
            if (known_ids.size() > 400) void'(known_ids.pop_front());
        end
    endtask

    task automatic write_cfg(input logic [4:0] parts, input logic [19:0] alpha);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= svp_pkg::CFG_NUM_PARTS;
        i_cfg_wdata <= svp_pkg::ALPHA_W'(parts);
        @(posedge i_clk);
        i_cfg_index <= svp_pkg::CFG_ALPHA;
        i_cfg_wdata <= alpha;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pm_part_count = parts;
        pm_alpha = alpha;
    endtask

    task automatic drain_all();
        @(negedge i_clk);
        while (pending_items.size() > 0 || i_valid || expected_placements.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_vertices(input int n_items);
        int          count;
        int          nn;
        logic [15:0] vid;
        logic [15:0] nid;
        count = 0;
        while (count < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                // stray item that does not close a vertex
                push_item(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)), 1'b0);
                count = count + 1;
            end else begin
                case ($urandom_range(0, 5))
                    0:       vid = 16'($urandom);
                    1:       vid = (known_ids.size() > 0)
                                 ? known_ids[$urandom_range(0, known_ids.size() - 1)]
                                 : 16'd0;
                    default: vid = 16'($urandom_range(0, 1023));
                endcase
                nn = int'($urandom_range(0, 6));
                if (nn == 0) begin
                    push_item(vid, 16'($urandom), 1'b0, 1'b1);
                    count = count + 1;
                end
                for (int j = 0; j < nn; j++) begin
                    if (known_ids.size() > 0 && $urandom_range(0, 9) < 7)
                        nid = known_ids[$urandom_range(0, known_ids.size() - 1)];
                    else
                        nid = 16'($urandom);
                    push_item(vid, nid, ($urandom_range(0, 9) != 0), (j == nn - 1));
                    count = count + 1;
                end
            end
        end
    endtask

    initial begin
        for (int v = 0; v < svp_pkg::MAP_DEPTH; v++) pm_map[v] = svp_pkg::UNASSIGNED;
        for (int p = 0; p < svp_pkg::MAX_PARTS; p++) begin
            pm_size[p] = '0;
            pm_cost[p] = 64'd65536;
            pm_hits[p] = '0;
        end
        pm_placed = '0;
        pm_part_count = 5'd2;
        pm_alpha = 20'd32768;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_cfg(5'd2, 20'd32768);

        @(negedge i_clk);
        // seeds at both ends of the id range
        push_item(16'hFFFF, 16'h0000, 1'b0, 1'b1);
        push_item(16'h0000, 16'hFFFF, 1'b0, 1'b1);
        // placed, placed, unplaced, and an ignored neighbour id
        push_item(16'h0005, 16'hFFFF, 1'b1, 1'b0);
        push_item(16'h0005, 16'h0000, 1'b1, 1'b0);
        push_item(16'h0005, 16'h04D2, 1'b1, 1'b0);
        push_item(16'h0005, 16'hFFFF, 1'b0, 1'b1);
        push_item(16'h0006, 16'h0005, 1'b1, 1'b1);
        push_item(16'h0007, 16'h0000, 1'b1, 1'b0);
        push_item(16'h0007, 16'h0006, 1'b1, 1'b1);
        // vertex placed a second time
        push_item(16'h0000, 16'h0007, 1'b1, 1'b1);
        push_item(16'hAAAA, 16'h5555, 1'b1, 1'b1);
        push_item(16'h5555, 16'hAAAA, 1'b1, 1'b1);
        random_vertices(PHASE_ITEMS);
        // sender pauses until every placement has come back
        drain_all();

        // partition count 0 acts as one partition, no balance weight
        write_cfg(5'd0, 20'd0);
        @(negedge i_clk);
        random_vertices(PHASE_ITEMS);
        drain_all();

        write_cfg(5'd16, 20'hFFFFF);
        @(negedge i_clk);
        random_vertices(PHASE_ITEMS);
        drain_all();

        // above the maximum, clamps to sixteen
        write_cfg(5'd31, 20'd65536);
        @(negedge i_clk);
        random_vertices(PHASE_ITEMS);
        drain_all();

        write_cfg(5'd1, 20'($urandom));
        @(negedge i_clk);
        random_vertices(PHASE_ITEMS);
        drain_all();

        write_cfg(5'($urandom_range(3, 15)), 20'($urandom));
        @(negedge i_clk);
        random_vertices(PHASE_ITEMS);
        drain_all();

        write_cfg(5'd2, 20'($urandom_range(0, 8192)));
        @(negedge i_clk);
        random_vertices(PHASE_ITEMS);
        drain_all();

        if (mismatches == 0 && expected_placements.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire
